>>> design/psd_pkg.sv
package psd_pkg;

  localparam int unsigned IN_W       = 16;
  localparam int unsigned DIFF_W     = IN_W + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned DOT_W      = PROD_W + 1;
  localparam int unsigned DEN_W      = PROD_W;
  localparam int unsigned HALF_W     = DEN_W / 2;
  localparam int unsigned NUM_W      = 75;
  localparam int unsigned QUO_W      = 41;
  localparam int unsigned RAD_W      = 42;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SREM_W     = ROOT_W + 2;
  localparam int unsigned DIV_STAGES  = QUO_W;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIST_W     = 21;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_BEFORE   = 2'd1,
    REGION_PAST     = 2'd2,
    REGION_DEGEN    = 2'd3
  } region_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] q;
    logic             byp;
    region_t          region;
  } div_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    region_t           region;
  } sqrt_t;

endpackage

>>> design/psd_front.sv
module psd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [psd_pkg::IN_W-1:0]  point_x,
  input  logic signed [psd_pkg::IN_W-1:0]  point_y,
  input  logic signed [psd_pkg::IN_W-1:0]  start_x,
  input  logic signed [psd_pkg::IN_W-1:0]  start_y,
  input  logic signed [psd_pkg::IN_W-1:0]  end_x,
  input  logic signed [psd_pkg::IN_W-1:0]  end_y,
  output logic                             out_valid,
  output psd_pkg::div_t                    out_data,
  input  logic                             out_ready
);

  logic [6:1] v;
  logic [6:1] rdy;

  // stage 1: differences
  logic signed [psd_pkg::DIFF_W-1:0] dx, dy, nx, ny, ex, ey;
  // stage 2: products
  logic signed [psd_pkg::PROD_W-1:0] p_dxdx, p_dydy, p_nxdx, p_nydy, p_dxny, p_dynx;
  logic signed [psd_pkg::PROD_W-1:0] p_nxnx, p_nyny, p_exex, p_eyey;
  // stage 3: sums
  logic [psd_pkg::DEN_W-1:0]        l2, sa, sb;
  logic signed [psd_pkg::DOT_W-1:0] t, cr;
  // stage 4: classification
  logic [psd_pkg::DEN_W-1:0]  den4, acr;
  logic [psd_pkg::QUO_W-1:0]  rad4;
  psd_pkg::region_t           region4;
  psd_pkg::region_t           region_c;
  logic [psd_pkg::DEN_W-1:0]  s_sel;
  // stage 5: partial products of the cross term squared
  logic [psd_pkg::DEN_W-1:0]  pp_hh, pp_hl, pp_ll, den5;
  logic [psd_pkg::QUO_W-1:0]  rad5;
  psd_pkg::region_t           region5;
  logic [psd_pkg::NUM_W-1:0]  num;

  assign rdy[6]   = !v[6] || out_ready;
  assign rdy[5]   = !v[5] || rdy[6];
  assign rdy[4]   = !v[4] || rdy[5];
  assign rdy[3]   = !v[3] || rdy[4];
  assign rdy[2]   = !v[2] || rdy[3];
  assign rdy[1]   = !v[1] || rdy[2];
  assign in_ready = rdy[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) v[6] <= v[5];
    end
  end

  always_comb begin
    priority if (l2 == '0) begin
      region_c = psd_pkg::REGION_DEGEN;
      s_sel    = sb;
    end else if (t < 0) begin
      region_c = psd_pkg::REGION_BEFORE;
      s_sel    = sa;
    end else if (t > $signed({1'b0, l2})) begin
      region_c = psd_pkg::REGION_PAST;
      s_sel    = sb;
    end else begin
      region_c = psd_pkg::REGION_INTERIOR;
      s_sel    = sa;
    end
  end

  // 256 * cross^2 from the three partial products
  assign num = ({{(psd_pkg::NUM_W-psd_pkg::DEN_W){1'b0}}, pp_hh} << (2 * psd_pkg::HALF_W + 8))
             + ({{(psd_pkg::NUM_W-psd_pkg::DEN_W){1'b0}}, pp_hl} << (psd_pkg::HALF_W + 9))
             + ({{(psd_pkg::NUM_W-psd_pkg::DEN_W){1'b0}}, pp_ll} << 8);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dx <= {end_x[15], end_x} - {start_x[15], start_x};
      dy <= {end_y[15], end_y} - {start_y[15], start_y};
      nx <= {point_x[15], point_x} - {start_x[15], start_x};
      ny <= {point_y[15], point_y} - {start_y[15], start_y};
      ex <= {point_x[15], point_x} - {end_x[15], end_x};
      ey <= {point_y[15], point_y} - {end_y[15], end_y};
    end
    if (rdy[2]) begin
      p_dxdx <= dx * dx;
      p_dydy <= dy * dy;
      p_nxdx <= nx * dx;
      p_nydy <= ny * dy;
      p_dxny <= dx * ny;
      p_dynx <= dy * nx;
      p_nxnx <= nx * nx;
      p_nyny <= ny * ny;
      p_exex <= ex * ex;
      p_eyey <= ey * ey;
    end
    if (rdy[3]) begin
      l2 <= p_dxdx + p_dydy;
      sa <= p_nxnx + p_nyny;
      sb <= p_exex + p_eyey;
      t  <= psd_pkg::DOT_W'(p_nxdx) + psd_pkg::DOT_W'(p_nydy);
      cr <= psd_pkg::DOT_W'(p_dxny) - psd_pkg::DOT_W'(p_dynx);
    end
    if (rdy[4]) begin
      den4    <= l2;
      region4 <= region_c;
      rad4    <= {s_sel[psd_pkg::QUO_W-9:0], 8'd0};
      acr     <= cr[psd_pkg::DOT_W-1] ? psd_pkg::DEN_W'(-cr) : cr[psd_pkg::DEN_W-1:0];
    end
    if (rdy[5]) begin
      pp_hh   <= acr[psd_pkg::DEN_W-1:psd_pkg::HALF_W] * acr[psd_pkg::DEN_W-1:psd_pkg::HALF_W];
      pp_hl   <= acr[psd_pkg::DEN_W-1:psd_pkg::HALF_W] * acr[psd_pkg::HALF_W-1:0];
      pp_ll   <= acr[psd_pkg::HALF_W-1:0] * acr[psd_pkg::HALF_W-1:0];
      den5    <= den4;
      rad5    <= rad4;
      region5 <= region4;
    end
    if (rdy[6]) begin
      // numerator is 256 * cross^2, split into running remainder and bits still to shift in
      out_data.rem    <= num[psd_pkg::NUM_W-1:psd_pkg::QUO_W];
      out_data.low    <= num[psd_pkg::QUO_W-1:0];
      out_data.den    <= den5;
      out_data.byp    <= (region5 != psd_pkg::REGION_INTERIOR);
      out_data.q      <= (region5 != psd_pkg::REGION_INTERIOR) ? rad5 : '0;
      out_data.region <= region5;
    end
  end

endmodule

>>> design/psd_div_cell.sv
module psd_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  psd_pkg::div_t in_data,
  output logic          in_ready,
  output logic          out_valid,
  output psd_pkg::div_t out_data,
  input  logic          out_ready
);

  logic [psd_pkg::DEN_W:0]   trial;
  logic [psd_pkg::DEN_W:0]   diff;
  logic                      ge;
  psd_pkg::div_t             nxt;

  assign in_ready = !out_valid || out_ready;
  assign trial    = {in_data.rem, in_data.low[psd_pkg::QUO_W-1]};
  assign diff     = trial - {1'b0, in_data.den};
  assign ge       = trial >= {1'b0, in_data.den};

  always_comb begin
    nxt = in_data;
    // bypassed transactions carry their radicand in q untouched
    if (!in_data.byp) begin
      nxt.rem = ge ? diff[psd_pkg::DEN_W-1:0] : trial[psd_pkg::DEN_W-1:0];
      nxt.low = {in_data.low[psd_pkg::QUO_W-2:0], 1'b0};
      nxt.q   = {in_data.q[psd_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= nxt;
  end

endmodule

>>> design/psd_sqrt_cell.sv
module psd_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  psd_pkg::sqrt_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  output psd_pkg::sqrt_t out_data,
  input  logic           out_ready
);

  logic [psd_pkg::SREM_W+1:0] cur;
  logic [psd_pkg::SREM_W+1:0] trial;
  logic [psd_pkg::SREM_W+1:0] diff;
  logic                       ge;
  psd_pkg::sqrt_t             nxt;

  assign in_ready = !out_valid || out_ready;
  assign cur      = {in_data.rem, in_data.rad[psd_pkg::RAD_W-1 -: 2]};
  assign trial    = {2'b00, in_data.root, 2'b01};
  assign diff     = cur - trial;
  assign ge       = cur >= trial;

  always_comb begin
    nxt        = in_data;
    nxt.rem    = ge ? diff[psd_pkg::SREM_W-1:0] : cur[psd_pkg::SREM_W-1:0];
    nxt.root   = {in_data.root[psd_pkg::ROOT_W-2:0], ge};
    nxt.rad    = {in_data.rad[psd_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= nxt;
  end

endmodule

>>> design/point_segment_distance.sv
// point to segment distance, 2d, signed q12.4 in, unsigned q13.8 out
// input channel: in_valid / in_stall with point, start and end coordinates;
// a transaction is taken on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with distance and region
// (0 interior, 1 before start, 2 past end, 3 degenerate segment)
// the data path is 6 front stages (differences, products, sums,
// classification, cross-squared partial products, numerator add), then
// 41 restoring divide cells, one quotient bit each, then 21 square root
// cells, one root bit each; the last root cell is the output register
// one transaction per cycle is accepted while the chain can move
// each cell moves on when it is empty or its neighbour takes its data, so
// while out_stall is high the cells behind fill their gaps, and in_stall
// rises once the whole chain is full
// reset clears every valid bit; nothing is kept between transactions
module point_segment_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [psd_pkg::IN_W-1:0]     point_x,
  input  logic signed [psd_pkg::IN_W-1:0]     point_y,
  input  logic signed [psd_pkg::IN_W-1:0]     start_x,
  input  logic signed [psd_pkg::IN_W-1:0]     start_y,
  input  logic signed [psd_pkg::IN_W-1:0]     end_x,
  input  logic signed [psd_pkg::IN_W-1:0]     end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psd_pkg::DIST_W-1:0]          distance,
  output logic [1:0]                          region
);

  logic                dv [psd_pkg::DIV_STAGES+1];
  psd_pkg::div_t       dd [psd_pkg::DIV_STAGES+1];
  logic                dr [psd_pkg::DIV_STAGES+1];
  logic                sv [psd_pkg::SQRT_STAGES+1];
  psd_pkg::sqrt_t      sd [psd_pkg::SQRT_STAGES+1];
  logic                sr [psd_pkg::SQRT_STAGES+1];
  logic                front_ready;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (dv[0]),
    .out_data  (dd[0]),
    .out_ready (dr[0])
  );

  assign in_stall = !front_ready;

  for (genvar i = 0; i < psd_pkg::DIV_STAGES; i++) begin : g_div
    psd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[i]),
      .in_data   (dd[i]),
      .in_ready  (dr[i]),
      .out_valid (dv[i+1]),
      .out_data  (dd[i+1]),
      .out_ready (dr[i+1])
    );
  end

  // quotient (or bypassed radicand) becomes the root chain's radicand
  assign sv[0]        = dv[psd_pkg::DIV_STAGES];
  assign sd[0].rem    = '0;
  assign sd[0].root   = '0;
  assign sd[0].rad    = {1'b0, dd[psd_pkg::DIV_STAGES].q};
  assign sd[0].region = dd[psd_pkg::DIV_STAGES].region;
  assign dr[psd_pkg::DIV_STAGES] = sr[0];

  for (genvar j = 0; j < psd_pkg::SQRT_STAGES; j++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[j]),
      .in_data   (sd[j]),
      .in_ready  (sr[j]),
      .out_valid (sv[j+1]),
      .out_data  (sd[j+1]),
      .out_ready (sr[j+1])
    );
  end

  assign sr[psd_pkg::SQRT_STAGES] = !out_stall;
  assign out_valid = sv[psd_pkg::SQRT_STAGES];
  assign distance  = sd[psd_pkg::SQRT_STAGES].root;
  assign region    = sd[psd_pkg::SQRT_STAGES].region;

  a_empty_output_no_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_reset_clears_output : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_degenerate_seg_bypass : assert property (@(posedge clk) disable iff (rst)
    dv[0] && (dd[0].den == '0) |-> dd[0].byp)
    else $error("zero-length segment sent through divider");

endmodule

>>> bench/point_segment_distance_test.sv
`timescale 1ns / 100ps

module point_segment_distance_test;

  typedef struct {
    logic [psd_pkg::DIST_W-1:0] span_len;
    psd_pkg::region_t           reg_code;
  } span_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [psd_pkg::IN_W-1:0] point_x = '0;
  logic signed [psd_pkg::IN_W-1:0] point_y = '0;
  logic signed [psd_pkg::IN_W-1:0] start_x = '0;
  logic signed [psd_pkg::IN_W-1:0] start_y = '0;
  logic signed [psd_pkg::IN_W-1:0] end_x = '0;
  logic signed [psd_pkg::IN_W-1:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [psd_pkg::DIST_W-1:0] distance;
  logic [1:0] region;

  span_result_t expected_spans[$];
  int errors = 0;
  int hold_cycles = 0;
  bit calm_receiver = 1'b0;
  bit calm_sender = 1'b0;

  point_segment_distance u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y),
    .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .region(region)
  );

  always #10 clk = ~clk;

  function automatic logic [127:0] root_floor(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] bitv;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // q13.8 length of a vector with q12.4 components
  function automatic logic [127:0] length_q8(longint x, longint y);
    logic [127:0] s;
    s = 128'(x * x) + 128'(y * y);
    return root_floor(s << 8);
  endfunction

  function automatic span_result_t predict_span(longint px, longint py, longint ax,
                                                longint ay, longint bx, longint by);
    span_result_t r;
    longint dx, dy, nx, ny, l2, t, cr;
    logic [127:0] d, num;
    dx = bx - ax;
    dy = by - ay;
    nx = px - ax;
    ny = py - ay;
    l2 = dx * dx + dy * dy;
    t = nx * dx + ny * dy;
    if (l2 == 0) begin
      r.reg_code = psd_pkg::REGION_DEGEN;
      d = length_q8(px - bx, py - by);
    end else if (t < 0) begin
      r.reg_code = psd_pkg::REGION_BEFORE;
      d = length_q8(nx, ny);
    end else if (t > l2) begin
      r.reg_code = psd_pkg::REGION_PAST;
      d = length_q8(px - bx, py - by);
    end else begin
      cr = dx * ny - dy * nx;
      if (cr < 0) cr = -cr;
      num = (128'(cr) * 128'(cr)) << 8;
      d = root_floor(num / 128'(l2));
      r.reg_code = psd_pkg::REGION_INTERIOR;
    end
    if (d > 128'd2097151) d = 128'd2097151;
    r.span_len = d[psd_pkg::DIST_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // output side, checked at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        span_result_t e;
        e = expected_spans.pop_front();
        if (distance !== e.span_len)
          report_mismatch($sformatf("distance %0d, expected %0d", distance, e.span_len));
        if (region !== e.reg_code)
          report_mismatch($sformatf("region %0d, expected %0d", region, e.reg_code));
      end
    end
  end

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (calm_receiver) begin
      out_stall <= 1'b0;
    end else if (random_gap() > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic signed [psd_pkg::IN_W-1:0] px, py, ax, ay, bx, by);
    int gap;
    point_x = px;
    point_y = py;
    start_x = ax;
    start_y = ay;
    end_x = bx;
    end_y = by;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_spans.push_back(predict_span(px, py, ax, ay, bx, by));
    @(negedge clk);
    gap = calm_sender ? 0 : random_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic test_extremes();
    send_item(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_item(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(-16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
    send_item(16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
    send_item(0, 0, 0, 0, 0, 0);
    send_item(-1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_regions();
    send_item(16, 16, 16, 16, 16, 16);
    send_item(48, 80, 16, 16, 16, 16);
    send_item(-32, 0, 0, 0, 64, 0);
    send_item(100, 3, 0, 0, 64, 0);
    send_item(32, 50, 0, 0, 64, 0);
    send_item(0, 50, 0, 0, 64, 0);
    send_item(64, -50, 0, 0, 64, 0);
    send_item(7, 11, 1, 2, 13, 29);
    send_item(-1, 0, 0, 0, 1, 0);
    send_item(2, 0, 0, 0, 1, 0);
    send_item(0, 0, -16'sh8000, 0, 16'sh7fff, 0);
    send_item(0, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000);
    wait_drained();
  endtask

  task automatic random_item();
    logic signed [psd_pkg::IN_W-1:0] v[6];
    int kind, lim;
    kind = $urandom_range(0, 9);
    lim = (kind < 5) ? 300 : 32767;
    foreach (v[i]) v[i] = (kind >= 7) ? psd_pkg::IN_W'($urandom)
                                      : psd_pkg::IN_W'($urandom_range(0, 2 * lim) - lim);
    if (kind == 4) begin
      v[4] = v[2];
      v[5] = v[3];
    end else if (kind == 3) begin
      v[4] = v[2] + psd_pkg::IN_W'($urandom_range(0, 2) - 1);
      v[5] = v[3] + psd_pkg::IN_W'($urandom_range(0, 2) - 1);
    end
    send_item(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic test_random();
    repeat (375) random_item();
    calm_receiver = 1'b1;
    calm_sender = 1'b1;
    repeat (80) random_item();
    calm_receiver = 1'b0;
    calm_sender = 1'b0;
    repeat (375) random_item();
    wait_drained();
  endtask

  task automatic test_backpressure();
    calm_sender = 1'b1;
    hold_cycles = 150;
    repeat (100) random_item();
    calm_sender = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_regions();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
